// ----- rtl/core/btns_pkg.sv -----
// Shared types and constants of the bounded top-N selector.
package btns_pkg;

   localparam int VALUE_W = 64;
   localparam int COUNT_W = 7;

   // Command codes carried on the request tuser.
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Register index, taken from paddr bit 2.
   localparam logic REG_KEEP_LARGEST = 1'b0;
   localparam logic REG_KEEP_COUNT   = 1'b1;

   // Operations broadcast to every cell of the chain.
   localparam logic [2:0] OP_HOLD        = 3'd0;
   localparam logic [2:0] OP_INSERT      = 3'd1;
   localparam logic [2:0] OP_DROP_INSERT = 3'd2;
   localparam logic [2:0] OP_ROT_L       = 3'd3;
   localparam logic [2:0] OP_ROT_R       = 3'd4;

   typedef struct packed {
      logic [2:0]         op;
      logic [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

// ----- rtl/core/btns_cell.sv -----
// One cell of the sorted chain: holds one value and trades it with its neighbors.
module btns_cell import btns_pkg::*; (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [VALUE_W-1:0] val_left,
   input  logic [VALUE_W-1:0] val_right,
   input  logic               gt_left,
   input  logic               gt_right,
   input  logic               held,
   output logic [VALUE_W-1:0] val,
   output logic               gt
);

   logic [VALUE_W-1:0] val_ff;
   logic [VALUE_W-1:0] val_in;

   // The held part of the chain is ascending, so the cells below the offered
   // value form a prefix of the chain.
   assign gt  = held && ($signed(val_ff) < $signed(ctl.value));
   assign val = val_ff;

   always_comb begin
      case (ctl.op)
         OP_INSERT: begin
            if (gt) begin
               val_in = val_ff;
            end else if (gt_left) begin
               val_in = ctl.value;
            end else begin
               val_in = val_left;
            end
         end
         OP_DROP_INSERT: begin
            // The lowest held value leaves; everything below the new value moves down.
            if (gt_right) begin
               val_in = val_right;
            end else if (gt) begin
               val_in = ctl.value;
            end else begin
               val_in = val_ff;
            end
         end
         OP_ROT_L: val_in = val_right;
         OP_ROT_R: val_in = val_left;
         default:  val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

// ----- rtl/core/bounded_top_n_selector_core.sv -----
// Top level of the bounded top-N selector: command decode, read sequencer and cell chain.
//
// Request items carry a command on req_tuser and a signed 64-bit value on req_tdata.
// An add compares the value against every cell of a chain of MAX_KEEP cells at
// once and the chain shifts to make room, so adds and clears run back to back at
// one item per cycle while no read runs, with no result.
// A read walks the whole chain as a ring, one step per cycle when not stalled,
// MAX_KEEP steps in all, and returns the held values best first on the rsp channel,
// tlast on the final one; the ring ends where it began, so the store is unchanged.
// In min mode the first result is captured at the first step; in max mode the best
// value reaches the output end after MAX_KEEP - held steps. The next request is
// taken once the walk has finished. An empty store gives one result with tuser
// (empty flag) set and data zero, and the read ends after that single step.
// No request is taken while a read runs. The rotation pauses whenever a result
// is due and the output register is full and not taken, so a stalled receiver
// loses nothing and holds off the request side.
// Reset clears the held count and sets keep_largest to 0 and keep_count to 1; the
// cell contents are not reset and need no clearing pass.
// Registers: keep_largest at byte address 0, keep_count at byte address 4.
module bounded_top_n_selector_core import btns_pkg::*; #(
   parameter int MAX_KEEP = 64
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [63:0]        req_tdata,   // [63:0] value
   input  logic [1:0]         req_tuser,   // [1:0] command
   // Result channel.
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata,   // [63:0] result_value
   output logic               rsp_tlast,
   output logic               rsp_tuser,   // [0] empty_res
   // Configuration port.
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int CW = $clog2(MAX_KEEP + 1);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_KEEP);
   localparam logic [CW-1:0] LAST_STEP = CW'(MAX_KEEP - 1);
   localparam logic [COUNT_W-1:0] LIMIT_HI = COUNT_W'(MAX_KEEP);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                keep_largest_ff, keep_largest_in;
   logic [COUNT_W-1:0]  keep_count_ff, keep_count_in;
   logic [CW-1:0]       held_ff, held_in;
   logic                state_ff, state_in;
   logic [CW-1:0]       step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_empty_ff, rsp_empty_in;

   cell_ctl_type        ctl;
   logic [VALUE_W-1:0]  cell_val [MAX_KEEP];
   logic [MAX_KEEP-1:0] cell_gt;
   logic [MAX_KEEP-1:0] held_mask;

   logic                csr_write;
   logic [COUNT_W-1:0]  limit;
   logic                accept;
   logic                out_free;
   logic                empty;
   logic                emit_now;
   logic                last_now;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      keep_largest_in = keep_largest_ff;
      keep_count_in   = keep_count_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_KEEP_LARGEST) begin
            keep_largest_in = csr_pwdata[0];
         end else begin
            keep_count_in = csr_pwdata[COUNT_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_KEEP_COUNT) ?
                       {{(32-COUNT_W){1'b0}}, keep_count_ff} : {31'b0, keep_largest_ff};

   // A count of zero acts as one; a count beyond the chain acts as the chain length.
   always_comb begin
      if (keep_count_ff == '0) begin
         limit = COUNT_W'(1);
      end else if (keep_count_ff > LIMIT_HI) begin
         limit = LIMIT_HI;
      end else begin
         limit = keep_count_ff;
      end
   end

   // Cell chain, closed into a ring for read-out.
   for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
      logic gt_l;
      logic gt_r;
      assign held_mask[g] = (CW'(g) < held_ff);
      if (g == 0) begin : g_first
         assign gt_l = 1'b1;
      end else begin : g_mid_l
         assign gt_l = cell_gt[g-1];
      end
      if (g == MAX_KEEP - 1) begin : g_last
         assign gt_r = 1'b0;
      end else begin : g_mid_r
         assign gt_r = cell_gt[g+1];
      end
      btns_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .val_left  (cell_val[(g + MAX_KEEP - 1) % MAX_KEEP]),
         .val_right (cell_val[(g + 1) % MAX_KEEP]),
         .gt_left   (gt_l),
         .gt_right  (gt_r),
         .held      (held_mask[g]),
         .val       (cell_val[g]),
         .gt        (cell_gt[g])
      );
   end

   // Command decode and read sequencer.
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign empty      = (held_ff == '0);

   // In min mode cell 0 shows entry step; in max mode the top cell shows
   // entry MAX_KEEP-1-step, which is held only near the end of the ring walk.
   always_comb begin
      if (empty) begin
         emit_now = 1'b1;
         last_now = 1'b1;
      end else if (keep_largest_ff) begin
         emit_now = (step_ff >= MAX_C - held_ff);
         last_now = (step_ff == LAST_STEP);
      end else begin
         emit_now = (step_ff < held_ff);
         last_now = (step_ff == held_ff - CW'(1));
      end
   end

   always_comb begin
      ctl.op       = OP_HOLD;
      ctl.value    = req_tdata;
      held_in      = held_ff;
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  CMD_ADD: begin
                     if (COUNT_W'(held_ff) < limit) begin
                        ctl.op  = OP_INSERT;
                        held_in = held_ff + CW'(1);
                     end else if (!empty) begin
                        // Full: the worst value falls off the far end, or stays
                        // if the offered one is no better.
                        ctl.op = keep_largest_ff ? OP_DROP_INSERT : OP_INSERT;
                     end
                  end
                  CMD_READ: begin
                     state_in = ST_READ;
                     step_in  = '0;
                  end
                  CMD_CLEAR: held_in = '0;
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (out_free || !emit_now) begin
               if (emit_now) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = last_now;
                  rsp_empty_in = empty;
                  if (empty) begin
                     rsp_value_in = '0;
                  end else if (keep_largest_ff) begin
                     rsp_value_in = cell_val[MAX_KEEP-1];
                  end else begin
                     rsp_value_in = cell_val[0];
                  end
               end
               if (!empty) begin
                  ctl.op = keep_largest_ff ? OP_ROT_R : OP_ROT_L;
               end
               if (empty || step_ff == LAST_STEP) begin
                  state_in = ST_IDLE;
                  step_in  = '0;
               end else begin
                  step_in = step_ff + CW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_largest_ff <= 1'b0;
         keep_count_ff   <= COUNT_W'(1);
         held_ff         <= '0;
         state_ff        <= ST_IDLE;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         keep_largest_ff <= keep_largest_in;
         keep_count_ff   <= keep_count_in;
         held_ff         <= held_in;
         state_ff        <= state_in;
         step_ff         <= step_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_empty_ff;

   // The held count never exceeds the chain length.
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= MAX_C)
      else $error("held count beyond chain length");

   // Between reads the held cells are ascending, so the below flags form a prefix.
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (((cell_gt >> 1) & ~cell_gt) == '0))
      else $error("held values out of order");

   // A read leaves the held count untouched.
   a_read_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> $stable(held_ff))
      else $error("held count changed during read");

   // An empty result is always a single, final, zero item.
   a_empty_res: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_last_ff && rsp_value_ff == '0))
      else $error("malformed empty result");

endmodule
